// ----- src/bcc_pkg.sv -----
// shared types and constants for the button click classifier
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

  localparam int TIME_BITS  = 32;
  localparam int LIMIT_BITS = 16;
  localparam int IN_BITS    = 40;
  localparam int OUT_BITS   = 8;
  localparam int CFG_IDX_BITS = 2;

  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [LIMIT_BITS-1:0] limit_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t REG_DEBOUNCE = 2'd0;
  localparam cfg_idx_t REG_CLICK    = 2'd1;
  localparam cfg_idx_t REG_LONG     = 2'd2;

  localparam limit_t DEBOUNCE_RESET = 16'd50;
  localparam limit_t CLICK_RESET    = 16'd200;
  localparam limit_t LONG_RESET     = 16'd1000;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PRESSED  = 3'd1,
    PH_RELEASED = 3'd2,
    PH_SECOND   = 3'd3,
    PH_LONG     = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  typedef struct packed {
    limit_t debounce;
    limit_t click;
    limit_t long_press;
  } limits_t;

  typedef struct packed {
    event_t event_code;
    logic   long_held;
  } result_t;

endpackage

`default_nettype wire

// ----- src/bcc_fsm.sv -----
// gesture state machine: phase, press start time and long press flag
`timescale 1ns / 1ps
`default_nettype none

module bcc_fsm (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic              button_level,
  input  wire bcc_pkg::time_t    now_ticks,
  input  wire bcc_pkg::limits_t  limits,
  output bcc_pkg::result_t       result
);

  bcc_pkg::phase_t phase_r, phase_nxt;
  bcc_pkg::time_t  press_start_r, press_start_nxt;
  logic            long_flag_r, long_flag_nxt;
  bcc_pkg::event_t ev;

  bcc_pkg::time_t  dl_debounce, dl_click, dl_long;

  // deadlines wrap modulo the timestamp width
  assign dl_debounce = press_start_r + bcc_pkg::TIME_BITS'(limits.debounce);
  assign dl_click    = press_start_r + bcc_pkg::TIME_BITS'(limits.click);
  assign dl_long     = press_start_r + bcc_pkg::TIME_BITS'(limits.long_press);

  always_comb begin
    phase_nxt       = phase_r;
    press_start_nxt = press_start_r;
    long_flag_nxt   = long_flag_r;
    ev              = bcc_pkg::EV_NONE;
    unique case (phase_r)
      bcc_pkg::PH_PRESSED: begin
        if (button_level && (now_ticks < dl_debounce)) begin
          phase_nxt = bcc_pkg::PH_IDLE;
        end else if (button_level) begin
          phase_nxt = bcc_pkg::PH_RELEASED;
        end else if (now_ticks > dl_long) begin
          long_flag_nxt = 1'b1;
          ev            = bcc_pkg::EV_LONG;
          phase_nxt     = bcc_pkg::PH_LONG;
        end
      end
      bcc_pkg::PH_RELEASED: begin
        // timeout wins over a new press in the same poll
        if (now_ticks > dl_click) begin
          ev        = bcc_pkg::EV_CLICK;
          phase_nxt = bcc_pkg::PH_IDLE;
        end else if (!button_level) begin
          phase_nxt = bcc_pkg::PH_SECOND;
        end
      end
      bcc_pkg::PH_SECOND: begin
        if (button_level) begin
          ev        = bcc_pkg::EV_DOUBLE;
          phase_nxt = bcc_pkg::PH_IDLE;
        end
      end
      bcc_pkg::PH_LONG: begin
        if (button_level) begin
          long_flag_nxt = 1'b0;
          phase_nxt     = bcc_pkg::PH_IDLE;
        end else begin
          long_flag_nxt = 1'b1;
        end
      end
      default: begin
        if (!button_level) begin
          phase_nxt       = bcc_pkg::PH_PRESSED;
          press_start_nxt = now_ticks;
        end else begin
          phase_nxt = bcc_pkg::PH_IDLE;
        end
      end
    endcase
  end

  assign result.event_code = ev;
  assign result.long_held  = long_flag_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= bcc_pkg::PH_IDLE;
      press_start_r <= '0;
      long_flag_r   <= 1'b0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      press_start_r <= press_start_nxt;
      long_flag_r   <= long_flag_nxt;
    end
  end

  // long flag tracks the long hold phase exactly
  a_flag_phase: assert property (@(posedge clk) disable iff (!rst_n)
    long_flag_r == (phase_r == bcc_pkg::PH_LONG))
    else $error("long flag out of step with phase");

  // a double click only closes a second press
  a_double_src: assert property (@(posedge clk) disable iff (!rst_n)
    (result.event_code == bcc_pkg::EV_DOUBLE) |-> (phase_r == bcc_pkg::PH_SECOND))
    else $error("double click outside second press");

  // a long press event enters long hold
  a_long_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (step && result.event_code == bcc_pkg::EV_LONG) |=>
      (phase_r == bcc_pkg::PH_LONG && long_flag_r))
    else $error("long press event did not enter long hold");

  // no step means state holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(press_start_r))
    else $error("state changed without a step");

endmodule

`default_nettype wire

// ----- src/button_click_classifier.sv -----
// top level: stream wrapper, limit registers and result register
// path: a request is held in the input register, then classified into the result register
// throughput: one request per cycle while results are taken, bound by the registered state update
// a waiting result lets the input register take one more request, then in_tready drops
// reset (rst_n low, synchronous) empties both registers, returns to idle and
// loads the limits 50 / 200 / 1000 ticks
`timescale 1ns / 1ps
`default_nettype none

module button_click_classifier (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input stream
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [bcc_pkg::IN_BITS-1:0]    in_tdata,   // [0] button_level, [32:1] now_ticks
  // result stream
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [bcc_pkg::OUT_BITS-1:0]        out_tdata,  // [1:0] event_code, [2] long_held
  // configuration writes
  input  wire logic                           cfg_we,
  input  wire bcc_pkg::cfg_idx_t              cfg_index,
  input  wire bcc_pkg::limit_t                cfg_wdata
);

  // limit registers
  bcc_pkg::limits_t limits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.debounce   <= bcc_pkg::DEBOUNCE_RESET;
      limits_r.click      <= bcc_pkg::CLICK_RESET;
      limits_r.long_press <= bcc_pkg::LONG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcc_pkg::REG_DEBOUNCE: limits_r.debounce   <= cfg_wdata;
        bcc_pkg::REG_CLICK:    limits_r.click      <= cfg_wdata;
        bcc_pkg::REG_LONG:     limits_r.long_press <= cfg_wdata;
        default: ;             // unmapped index, write dropped
      endcase
    end
  end

  // input register
  logic            in_valid_r;
  logic            level_r;
  bcc_pkg::time_t  now_r;
  logic            advance;
  logic            in_take;

  // the poll moves on when the result slot is free or being drained
  assign advance   = in_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      level_r <= in_tdata[0];
      now_r   <= in_tdata[bcc_pkg::TIME_BITS:1];
    end
  end

  // gesture classification, one poll per step
  bcc_pkg::result_t step_res;

  bcc_fsm u_fsm (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .button_level (level_r),
    .now_ticks    (now_r),
    .limits       (limits_r),
    .result       (step_res)
  );

  // result register
  logic             out_valid_r;
  bcc_pkg::result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(bcc_pkg::OUT_BITS - 3){1'b0}}, res_r.long_held, res_r.event_code};

  // a waiting result is never dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("pending result lost");

  // input side only backs up behind a full input register and a waiting result
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without cause");

  // every accepted poll produces a result
  a_take_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("step without result");

endmodule

`default_nettype wire

// ----- tb/bcc_checker.sv -----
// checker for the button click classifier: predicts each poll's result and compares
`timescale 1ns / 1ps

module bcc_checker
  import bcc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  input  wire logic                 in_tready,
  input  wire logic [IN_BITS-1:0]   in_tdata,   // [0] button_level, [32:1] now_ticks
  input  wire logic                 out_tvalid,
  input  wire logic                 out_tready,
  input  wire logic [OUT_BITS-1:0]  out_tdata,  // [1:0] event_code, [2] long_held
  input  wire logic                 cfg_we,
  input  wire cfg_idx_t             cfg_index,
  input  wire limit_t               cfg_wdata,
  output int                        fail_count,
  output int                        pending,
  output int                        n_checked,
  output int                        n_click,
  output int                        n_double,
  output int                        n_long
);

  // shadow of the block's gesture state and limit registers
  phase_t  btn_phase;
  time_t   press_t0;
  logic    long_on;
  limits_t lims;
  result_t results_due[$];

  // deadline relative to the first press, wrapping at the timestamp width
  function automatic time_t due(input limit_t lim);
    return press_t0 + time_t'(lim);
  endfunction

  function automatic result_t classify_poll(input logic released, input time_t now);
    result_t r;
    r.event_code = EV_NONE;
    case (btn_phase)
      PH_PRESSED: begin
        if (released && now < due(lims.debounce)) begin
          btn_phase = PH_IDLE;
        end else if (released) begin
          btn_phase = PH_RELEASED;
        end else if (now > due(lims.long_press)) begin
          long_on      = 1'b1;
          r.event_code = EV_LONG;
          btn_phase    = PH_LONG;
        end
      end
      PH_RELEASED: begin
        // the timeout wins over a new press in the same poll
        if (now > due(lims.click)) begin
          r.event_code = EV_CLICK;
          btn_phase    = PH_IDLE;
        end else if (!released) begin
          btn_phase = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if (released) begin
          r.event_code = EV_DOUBLE;
          btn_phase    = PH_IDLE;
        end
      end
      PH_LONG: begin
        long_on = !released;
        if (released) btn_phase = PH_IDLE;
      end
      default: begin
        if (!released) begin
          btn_phase = PH_PRESSED;
          press_t0  = now;
        end else begin
          btn_phase = PH_IDLE;
        end
      end
    endcase
    r.long_held = long_on;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t got, want;
    if (!rst_n) begin
      btn_phase       = PH_IDLE;
      press_t0        = '0;
      long_on         = 1'b0;
      lims.debounce   = DEBOUNCE_RESET;
      lims.click      = CLICK_RESET;
      lims.long_press = LONG_RESET;
      results_due.delete();
      fail_count = 0;
      n_checked  = 0;
      n_click    = 0;
      n_double   = 0;
      n_long     = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.event_code = event_t'(out_tdata[1:0]);
        got.long_held  = out_tdata[2];
        n_checked++;
        case (got.event_code)
          EV_CLICK:  n_click++;
          EV_DOUBLE: n_double++;
          EV_LONG:   n_long++;
          default: ;
        endcase
        if (results_due.size() == 0) begin
          $display("%0t: result with none expected, event_code %0d long_held %0b",
                   $time, got.event_code, got.long_held);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          if (got.event_code !== want.event_code) begin
            $display("%0t: event_code expected %0d got %0d",
                     $time, want.event_code, got.event_code);
            fail_count++;
          end
          if (got.long_held !== want.long_held) begin
            $display("%0t: long_held expected %0b got %0b",
                     $time, want.long_held, got.long_held);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE: lims.debounce   = cfg_wdata;
          REG_CLICK:    lims.click      = cfg_wdata;
          REG_LONG:     lims.long_press = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        results_due.push_back(classify_poll(in_tdata[0], time_t'(in_tdata[32:1])));
    end
    pending = results_due.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// testbench top for the button click classifier: stimulus, stream pacing and verdict
`timescale 1ns / 1ps

module tb_top;
  import bcc_pkg::*;

  localparam int       HOLD_OFF_CYCLES = 300;     // one long receiver hold-off
  localparam int       PHASE_ITEMS     = 66;      // polls per random limit setting, at least
  localparam int       DRAIN_CYCLES    = 4;       // extra wait after the last result
  localparam int       LIMIT_CYCLES    = 400000;  // watchdog
  localparam cfg_idx_t REG_UNUSED      = 2'd3;    // index with no register behind it
  localparam logic     LVL_PRESSED     = 1'b0;    // active-low pin
  localparam logic     LVL_RELEASED    = 1'b1;

  // pacing mixes for the two stream sides
  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [IN_BITS-1:0] in_tdata   = '0;   // [0] button_level, [32:1] now_ticks
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_BITS-1:0] out_tdata;        // [1:0] event_code, [2] long_held
  logic               cfg_we     = 1'b0;
  cfg_idx_t           cfg_index  = REG_DEBOUNCE;
  limit_t             cfg_wdata  = '0;

  int         fail_count, pending, n_checked, n_click, n_double, n_long;
  int         cycle_count   = 0;
  int         polls_sent    = 0;
  int         hold_off_left = HOLD_OFF_CYCLES;
  logic       hold_off_req  = 1'b0;
  idle_mode_t idle_mode     = IDLE_NONE;
  limits_t    cur_lims      = '{debounce: DEBOUNCE_RESET, click: CLICK_RESET,
                                long_press: LONG_RESET};
  time_t      tick_now      = 32'd5000;

  always #5 clk = ~clk;

  button_click_classifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  bcc_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .n_checked  (n_checked),
    .n_click    (n_click),
    .n_double   (n_double),
    .n_long     (n_long)
  );

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side pacing; the one-shot hold-off counts in this process only,
  // so the sender keeps offering requests until the block backs up
  always @(posedge clk) begin
    if (hold_off_req && hold_off_left != 0) begin
      out_tready    <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: out_tready <= ($urandom_range(0, 99) >= 81);
        IDLE_BOTH:     out_tready <= ($urandom_range(0, 99) >= 8);
        default:       out_tready <= 1'b1;
      endcase
    end
  end

  function automatic bit sender_rests();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 81;
      IDLE_BOTH:   return $urandom_range(0, 99) < 8;
      default:     return 1'b0;
    endcase
  endfunction

  // offset just around a limit, or anywhere from zero to a bit past it
  function automatic time_t near_limit(input limit_t lim);
    case ($urandom_range(0, 3))
      0:       return time_t'(lim) - 1;
      1:       return time_t'(lim);
      2:       return time_t'(lim) + 1;
      default: return time_t'($urandom_range(0, int'(lim) + int'(lim) / 2 + 2));
    endcase
  endfunction

  // one poll request; called at a rising edge, returns at the accepting edge.
  // ready is looked at on the falling edge, where it is settled for the next edge
  task automatic send_poll(input logic level, input time_t ticks);
    while (sender_rests()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_BITS - 33){1'b0}}, ticks, level};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    polls_sent++;
  endtask

  // stop offering and wait until every owed result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all three limits back to back, optionally poke the unused index too
  task automatic load_limits(input limits_t l, input bit stray);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_wdata <= l.debounce;
    @(posedge clk);
    cfg_index <= REG_CLICK;
    cfg_wdata <= l.click;
    @(posedge clk);
    cfg_index <= REG_LONG;
    cfg_wdata <= l.long_press;
    @(posedge clk);
    if (stray) begin
      cfg_index <= REG_UNUSED;
      cfg_wdata <= limit_t'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_lims = l;
  endtask

  // one gesture with timings placed around the current limits
  task automatic play_gesture();
    time_t t0, t;
    int    n;
    t0 = tick_now;
    // now and then start close to the top so deadlines wrap past zero
    if ($urandom_range(0, 19) == 0)
      t0 = 32'hFFFF_FFFF - time_t'($urandom_range(0, 2 * int'(cur_lims.long_press) + 4));
    t = t0;
    case ($urandom_range(0, 9))
      0, 1: begin  // single click, last poll lands around the click window end
        send_poll(LVL_PRESSED, t0);
        if ($urandom_range(0, 1))
          send_poll(LVL_PRESSED, t0 + near_limit(cur_lims.debounce) / 2);
        send_poll(LVL_RELEASED, t0 + near_limit(cur_lims.debounce));
        send_poll(LVL_RELEASED, t0 + near_limit(cur_lims.click));
        t = t0 + time_t'(cur_lims.click) + time_t'($urandom_range(1, 3));
        send_poll(LVL_RELEASED, t);
      end
      2, 3: begin  // double click, second press near the click window end
        send_poll(LVL_PRESSED, t0);
        send_poll(LVL_RELEASED, t0 + time_t'(cur_lims.debounce) + time_t'($urandom_range(0, 2)));
        t = t0 + near_limit(cur_lims.click);
        send_poll(LVL_PRESSED, t);
        t = t + time_t'($urandom_range(0, 30));
        send_poll(LVL_RELEASED, t);
      end
      4, 5: begin  // long press, held on for a while, then let go
        send_poll(LVL_PRESSED, t0);
        send_poll(LVL_PRESSED, t0 + near_limit(cur_lims.long_press));
        t = t0 + time_t'(cur_lims.long_press) + time_t'($urandom_range(1, 4));
        send_poll(LVL_PRESSED, t);
        n = $urandom_range(0, 3);
        repeat (n) begin
          t = t + time_t'($urandom_range(0, 100));
          send_poll(LVL_PRESSED, t);
        end
        t = t + time_t'($urandom_range(0, 10));
        send_poll(LVL_RELEASED, t);
      end
      6: begin  // contact bounce, release inside, at or just past the debounce window
        send_poll(LVL_PRESSED, t0);
        t = t0 + time_t'($urandom_range(0, int'(cur_lims.debounce) + 1));
        send_poll(LVL_RELEASED, t);
      end
      7, 8: begin  // random levels on a forward-running clock
        n = $urandom_range(2, 8);
        repeat (n) begin
          t = t + time_t'($urandom_range(0, int'(cur_lims.click) / 2 + 3));
          send_poll(logic'($urandom_range(0, 1)), t);
        end
      end
      default: begin  // noise: any level at any timestamp
        n = $urandom_range(1, 3);
        repeat (n) send_poll(logic'($urandom_range(0, 1)), time_t'($urandom));
      end
    endcase
    // often let everything time out so the next gesture starts from idle
    if ($urandom_range(0, 1)) begin
      t = t0 + time_t'(cur_lims.click) + time_t'(cur_lims.long_press) + 2;
      send_poll(LVL_RELEASED, t);
    end
    tick_now = t + time_t'($urandom_range(1, 40));
  endtask

  initial begin
    limits_t    lims;
    idle_mode_t mode;
    int         phase_start;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on the reset limits 50 / 200 / 1000
    // contact bounce: release inside the debounce window
    send_poll(LVL_PRESSED, 32'd100);
    send_poll(LVL_RELEASED, 32'd120);
    // single click, timeout poll one tick past the click window
    send_poll(LVL_PRESSED, 32'd200);
    send_poll(LVL_RELEASED, 32'd260);
    send_poll(LVL_RELEASED, 32'd300);
    send_poll(LVL_RELEASED, 32'd401);
    // double click
    send_poll(LVL_PRESSED, 32'd1000);
    send_poll(LVL_RELEASED, 32'd1100);
    send_poll(LVL_PRESSED, 32'd1150);
    send_poll(LVL_RELEASED, 32'd1300);
    // click timeout beats a new press seen in the same poll
    send_poll(LVL_PRESSED, 32'd2000);
    send_poll(LVL_RELEASED, 32'd2060);
    send_poll(LVL_PRESSED, 32'd2201);
    send_poll(LVL_RELEASED, 32'd2210);
    // long press, flag stays up until release
    send_poll(LVL_PRESSED, 32'd3000);
    send_poll(LVL_PRESSED, 32'd3500);
    send_poll(LVL_PRESSED, 32'd4001);
    send_poll(LVL_PRESSED, 32'd4100);
    send_poll(LVL_RELEASED, 32'd4200);
    // deadlines wrapping past zero, timestamp extremes
    send_poll(LVL_PRESSED, 32'hFFFF_FFF0);
    send_poll(LVL_RELEASED, 32'h0000_0000);
    send_poll(LVL_PRESSED, 32'hFFFF_FFF0);
    send_poll(LVL_PRESSED, 32'h0000_0005);
    send_poll(LVL_PRESSED, 32'h0000_0400);
    send_poll(LVL_RELEASED, 32'hFFFF_FFFF);

    // random gestures under a series of limit settings and pacing mixes
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin lims = '{16'd10, 16'd15, 16'd20};          mode = IDLE_NONE;     end
        1: begin lims = '0;                                  mode = IDLE_SENDER;   end
        2: begin lims = '{16'hFFFF, 16'hFFFF, 16'hFFFF};    mode = IDLE_RECEIVER; end
        3: begin lims = limits_t'($urandom);                 mode = IDLE_BOTH;     end
        4: begin
          lims = '{DEBOUNCE_RESET, CLICK_RESET, LONG_RESET};
          mode = IDLE_NONE;
        end
        5: begin
          lims = '{limit_t'($urandom_range(0, 300)), limit_t'($urandom_range(0, 300)),
                   limit_t'($urandom_range(0, 300))};
          mode = IDLE_SENDER;
        end
        6: begin lims = '{16'hFFFF, 16'd0, 16'd1};          mode = IDLE_RECEIVER; end
        default: begin lims = limits_t'({$urandom, $urandom}); mode = IDLE_BOTH; end
      endcase
      wait_drained();
      load_limits(lims, p == 3 || p == 6);
      idle_mode = mode;
      // receiver goes quiet for a long stretch while requests keep coming
      if (p == 4) hold_off_req <= 1'b1;
      phase_start = polls_sent;
      while (polls_sent - phase_start < PHASE_ITEMS) play_gesture();
    end

    wait_drained();
    $display("%0d polls: directed gestures on reset limits, then 8 limit settings from",
             polls_sent);
    $display("all-zero to full-scale; %0d results, %0d clicks, %0d doubles, %0d long presses",
             n_checked, n_click, n_double, n_long);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
